// ----- design/sem_pkg.sv -----
`timescale 1ns / 1ps
package sem_pkg;
   localparam int MaxWidthDefault  = 1024;
   localparam int MaxHeightDefault = 4096;
   localparam int WidthRegBits     = 11;
   localparam int HeightRegBits    = 13;
   localparam int CsrDataBits      = 13;
   localparam int CsrIndexBits     = 1;
   localparam int WidthReset       = 640;
   localparam int HeightReset      = 480;
   localparam int ChanBits         = 8;
   localparam int RowOutBits       = 12;
   localparam int ColOutBits       = 10;
   localparam int MagMax           = 255;
   localparam int SqSatLevel       = 65025;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [ChanBits-1:0] red;
      logic [ChanBits-1:0] green;
      logic [ChanBits-1:0] blue;
   } pixel_type;

   // one pixel with the two line store values read at its column
   typedef struct packed {
      pixel_type pix;
      pixel_type far_px;
      pixel_type near_px;
   } item_type;

   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_LOOK = 2'b10
   } front_state_type;

   typedef enum logic [5:0] {
      B_IDLE = 6'b000001,
      B_GRAD = 6'b000010,
      B_SQR  = 6'b000100,
      B_SUM  = 6'b001000,
      B_ROOT = 6'b010000,
      B_OUT  = 6'b100000
   } back_state_type;
endpackage

// ----- design/sem_ram.sv -----
`timescale 1ns / 1ps
module sem_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

// ----- design/sem_fifo.sv -----
`timescale 1ns / 1ps
module sem_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sem_pkg::item_type  push_item,
   input  logic               pop,
   output sem_pkg::item_type  head_item,
   output logic               not_empty,
   output logic               full,
   output logic [1:0]         count
);
   sem_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign count     = count_ff;
endmodule

// ----- design/sem_front.sv -----
`timescale 1ns / 1ps
module sem_front #(
   parameter int MAX_WIDTH  = sem_pkg::MaxWidthDefault,
   parameter int MAX_HEIGHT = sem_pkg::MaxHeightDefault,
   localparam int WB = $clog2(MAX_WIDTH + 1),
   localparam int HB = $clog2(MAX_HEIGHT + 1),
   localparam int AW = $clog2(MAX_WIDTH)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             restart,
   input  logic [WB-1:0]                    eff_w,
   input  logic [HB-1:0]                    eff_h,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_flush,
   input  logic [sem_pkg::ChanBits-1:0]     req_red,
   input  logic [sem_pkg::ChanBits-1:0]     req_green,
   input  logic [sem_pkg::ChanBits-1:0]     req_blue,
   input  logic                             q_full,
   output logic                             q_push,
   output sem_pkg::item_type                q_item
);
   sem_pkg::front_state_type state_ff, state_in;
   logic [WB-1:0]       in_col_ff, in_col_in;
   logic [HB-1:0]       in_row_ff, in_row_in;
   logic [WB-1:0]       drain_ff, drain_in;
   logic [AW-1:0]       idx_ff, idx_in;
   sem_pkg::pixel_type  pix_ff, pix_in;
   logic [AW-1:0]       ram_addr;
   logic                ram_we;
   logic [47:0]         ram_wdata, ram_rdata;
   logic                accept, draining;
   logic [WB:0]         col_next;
   sem_pkg::pixel_type  near_px, far_px;

   assign near_px = ram_rdata[47:24];
   assign far_px  = ram_rdata[23:0];

   assign req_stall = !((state_ff == sem_pkg::F_IDLE) && !q_full);
   assign accept    = req_valid && !req_stall;
   assign draining  = (in_row_ff >= eff_h);
   assign col_next  = (WB+1)'(in_col_ff) + (WB+1)'(1);

   always_comb begin
      state_in  = state_ff;
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      drain_in  = drain_ff;
      idx_in    = idx_ff;
      pix_in    = pix_ff;
      ram_addr  = in_col_ff[AW-1:0];
      ram_we    = 1'b0;
      ram_wdata = {pix_ff, near_px};
      q_push    = 1'b0;
      q_item    = '{pix: pix_ff, far_px: far_px, near_px: near_px};
      unique case (state_ff)
         sem_pkg::F_IDLE: begin
            // a flush outside the drain is taken and dropped
            if (accept && (draining || !req_flush)) begin
               idx_in   = in_col_ff[AW-1:0];
               pix_in   = '{red: req_red, green: req_green, blue: req_blue};
               if (draining) begin
                  pix_in = '0;
               end
               state_in = sem_pkg::F_LOOK;
               if (col_next >= (WB+1)'(eff_w)) begin
                  in_col_in = '0;
                  if (!draining) begin
                     in_row_in = in_row_ff + HB'(1);
                  end
               end else begin
                  in_col_in = col_next[WB-1:0];
               end
               if (draining) begin
                  if (drain_ff == eff_w) begin
                     in_col_in = '0;
                     in_row_in = '0;
                     drain_in  = '0;
                  end else begin
                     drain_in = drain_ff + WB'(1);
                  end
               end
            end
         end
         sem_pkg::F_LOOK: begin
            ram_addr = idx_ff;
            ram_we   = 1'b1;
            q_push   = 1'b1;
            state_in = sem_pkg::F_IDLE;
         end
         default: state_in = sem_pkg::F_IDLE;
      endcase
      if (restart) begin
         in_col_in = '0;
         in_row_in = '0;
         drain_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sem_pkg::F_IDLE;
         in_col_ff <= '0;
         in_row_ff <= '0;
         drain_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         drain_ff  <= drain_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pix_ff <= pix_in;
   end

   // near line in the upper half, far line in the lower half
   sem_ram #(
      .WIDTH(48),
      .DEPTH(MAX_WIDTH)
   ) u_line_ram (
      .clock(clock),
      .addr (ram_addr),
      .we   (ram_we),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );
endmodule

// ----- design/sem_back.sv -----
`timescale 1ns / 1ps
module sem_back #(
   parameter int MAX_WIDTH  = sem_pkg::MaxWidthDefault,
   parameter int MAX_HEIGHT = sem_pkg::MaxHeightDefault,
   localparam int WB = $clog2(MAX_WIDTH + 1),
   localparam int HB = $clog2(MAX_HEIGHT + 1),
   localparam int FB = $clog2(MAX_WIDTH + 2)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               restart,
   input  logic [WB-1:0]                      eff_w,
   input  logic [HB-1:0]                      eff_h,
   input  logic                               q_valid,
   input  sem_pkg::item_type                  q_item,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [sem_pkg::ChanBits-1:0]       rsp_out_red,
   output logic [sem_pkg::ChanBits-1:0]       rsp_out_green,
   output logic [sem_pkg::ChanBits-1:0]       rsp_out_blue,
   output logic [sem_pkg::RowOutBits-1:0]     rsp_out_row,
   output logic [sem_pkg::ColOutBits-1:0]     rsp_out_col,
   output logic                               rsp_frame_last
);
   sem_pkg::back_state_type state_ff, state_in;
   sem_pkg::pixel_type win_ff [9];
   sem_pkg::pixel_type win_in [9];
   logic [FB-1:0]      fill_ff, fill_in;
   logic [HB-1:0]      erow_ff, erow_in;
   logic [WB-1:0]      ecol_ff, ecol_in;
   sem_pkg::pixel_type out_pix_ff, out_pix_in;
   logic [HB-1:0]      out_row_ff, out_row_in;
   logic [WB-1:0]      out_col_ff, out_col_in;
   logic               out_last_ff, out_last_in;
   logic signed [10:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [19:0]        gx2_ff, gx2_in, gy2_ff, gy2_in;
   logic [15:0]        v_ff, v_in;
   logic [7:0]         root_ff, root_in, bit_ff, bit_in;
   logic [9:0]         gx_pos, gx_neg, gy_pos, gy_neg, gx_abs, gy_abs;
   logic [20:0]        sq_sum;
   logic [7:0]         trial;
   logic [15:0]        trial_sq;
   logic [7:0]         root_next;
   logic [HB:0]        row_p1;
   logic [WB:0]        col_p1;
   logic               interior, last_px;

   function automatic logic [9:0] red10(input sem_pkg::pixel_type p);
      red10 = {2'b00, p.red};
   endfunction

   assign q_pop  = (state_ff == sem_pkg::B_IDLE) && q_valid;
   assign row_p1 = (HB+1)'(erow_ff) + (HB+1)'(1);
   assign col_p1 = (WB+1)'(ecol_ff) + (WB+1)'(1);
   assign interior = (erow_ff != '0) && (row_p1 < (HB+1)'(eff_h))
                  && (ecol_ff != '0) && (col_p1 < (WB+1)'(eff_w));
   assign last_px  = (row_p1 >= (HB+1)'(eff_h)) && (col_p1 >= (WB+1)'(eff_w));

   // gradients on the red channel of the shifted window
   assign gx_pos = red10(win_ff[2]) + (red10(win_ff[5]) << 1) + red10(win_ff[8]);
   assign gx_neg = red10(win_ff[0]) + (red10(win_ff[3]) << 1) + red10(win_ff[6]);
   assign gy_pos = red10(win_ff[6]) + (red10(win_ff[7]) << 1) + red10(win_ff[8]);
   assign gy_neg = red10(win_ff[0]) + (red10(win_ff[1]) << 1) + red10(win_ff[2]);
   assign gx_in  = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
   assign gy_in  = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
   assign gx_abs = gx_ff[10] ? 10'(-gx_ff) : gx_ff[9:0];
   assign gy_abs = gy_ff[10] ? 10'(-gy_ff) : gy_ff[9:0];
   assign gx2_in = 20'(gx_abs) * 20'(gx_abs);
   assign gy2_in = 20'(gy_abs) * 20'(gy_abs);
   assign sq_sum = 21'(gx2_ff) + 21'(gy2_ff);

   // one result bit of the integer square root per cycle
   assign trial     = root_ff | bit_ff;
   assign trial_sq  = 16'(trial) * 16'(trial);
   assign root_next = (trial_sq <= v_ff) ? trial : root_ff;

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      erow_in     = erow_ff;
      ecol_in     = ecol_ff;
      out_pix_in  = out_pix_ff;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      out_last_in = out_last_ff;
      v_in        = v_ff;
      root_in     = root_ff;
      bit_in      = bit_ff;
      for (int r = 0; r < 3; r++) begin
         win_in[r*3]   = win_ff[r*3+1];
         win_in[r*3+1] = win_ff[r*3+2];
      end
      win_in[2] = q_item.far_px;
      win_in[5] = q_item.near_px;
      win_in[8] = q_item.pix;
      unique case (state_ff)
         sem_pkg::B_IDLE: begin
            if (q_valid) begin
               if (fill_ff <= FB'(eff_w)) begin
                  fill_in = fill_ff + FB'(1);
               end else begin
                  out_pix_in  = win_in[4];
                  out_row_in  = erow_ff;
                  out_col_in  = ecol_ff;
                  out_last_in = last_px;
                  state_in    = interior ? sem_pkg::B_GRAD : sem_pkg::B_OUT;
                  if (last_px) begin
                     fill_in = '0;
                     erow_in = '0;
                     ecol_in = '0;
                  end else if (col_p1 >= (WB+1)'(eff_w)) begin
                     ecol_in = '0;
                     erow_in = row_p1[HB-1:0];
                  end else begin
                     ecol_in = col_p1[WB-1:0];
                  end
               end
            end
         end
         sem_pkg::B_GRAD: state_in = sem_pkg::B_SQR;
         sem_pkg::B_SQR:  state_in = sem_pkg::B_SUM;
         sem_pkg::B_SUM: begin
            if (sq_sum >= 21'(sem_pkg::SqSatLevel)) begin
               out_pix_in = '{red: 8'(sem_pkg::MagMax), green: 8'(sem_pkg::MagMax),
                              blue: 8'(sem_pkg::MagMax)};
               state_in   = sem_pkg::B_OUT;
            end else begin
               v_in     = sq_sum[15:0];
               root_in  = '0;
               bit_in   = 8'h80;
               state_in = sem_pkg::B_ROOT;
            end
         end
         sem_pkg::B_ROOT: begin
            root_in = root_next;
            bit_in  = bit_ff >> 1;
            if (bit_ff[0]) begin
               out_pix_in = '{red: root_next, green: root_next, blue: root_next};
               state_in   = sem_pkg::B_OUT;
            end
         end
         sem_pkg::B_OUT: begin
            if (!rsp_stall) begin
               state_in = sem_pkg::B_IDLE;
            end
         end
         default: state_in = sem_pkg::B_IDLE;
      endcase
      if (restart) begin
         fill_in = '0;
         erow_in = '0;
         ecol_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sem_pkg::B_IDLE;
         fill_ff  <= '0;
         erow_ff  <= '0;
         ecol_ff  <= '0;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         erow_ff  <= erow_in;
         ecol_ff  <= ecol_in;
         if (q_pop) begin
            for (int i = 0; i < 9; i++) begin
               win_ff[i] <= win_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      out_pix_ff  <= out_pix_in;
      out_row_ff  <= out_row_in;
      out_col_ff  <= out_col_in;
      out_last_ff <= out_last_in;
      gx_ff       <= gx_in;
      gy_ff       <= gy_in;
      gx2_ff      <= gx2_in;
      gy2_ff      <= gy2_in;
      v_ff        <= v_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
   end

   assign rsp_valid      = (state_ff == sem_pkg::B_OUT);
   assign rsp_out_red    = out_pix_ff.red;
   assign rsp_out_green  = out_pix_ff.green;
   assign rsp_out_blue   = out_pix_ff.blue;
   assign rsp_out_row    = sem_pkg::RowOutBits'(out_row_ff);
   assign rsp_out_col    = sem_pkg::ColOutBits'(out_col_ff);
   assign rsp_frame_last = out_last_ff;
endmodule

// ----- design/sobel_edge_magnitude_top.sv -----
`timescale 1ns / 1ps
// Sobel edge magnitude over a raster RGB stream.
// req_*: one pixel per transfer in raster order; req_flush marks an item
// with no pixel. After the last pixel of a frame send width+1 flush items
// to drain it. A flush at any other time is taken and dropped.
// rsp_*: zero or one pixel per item, lagging the input by width+1 items.
// Interior pixels carry the red-channel gradient magnitude, clamped to 255,
// on all three channels; border pixels pass through. rsp_frame_last marks
// the last pixel, after which a new frame starts.
// csr_*: image_width (index 0) and image_height (index 1); a write restarts
// the frame. Write only while the block is idle.
// Stepping: the front takes an item and reads the line RAM in F_IDLE, then
// writes it back in F_LOOK before it takes the next; the back pops a fill item
// in B_IDLE, shows a border pixel in B_OUT, and steps an interior pixel through
// B_GRAD, B_SQR, B_SUM, the 8-step square root in B_ROOT unless the magnitude
// saturates, and B_OUT. An accepted item passes F_LOOK and the queue before the
// back takes it, and it may wait behind earlier items.
// A 2-entry queue lets the front keep taking items while rsp_stall holds
// a result. Reset clears counters and the window; line RAM is not cleared.
module sobel_edge_magnitude_top #(
   parameter int MAX_WIDTH  = sem_pkg::MaxWidthDefault,
   parameter int MAX_HEIGHT = sem_pkg::MaxHeightDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_flush,
   input  logic [sem_pkg::ChanBits-1:0]         req_red,
   input  logic [sem_pkg::ChanBits-1:0]         req_green,
   input  logic [sem_pkg::ChanBits-1:0]         req_blue,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sem_pkg::ChanBits-1:0]         rsp_out_red,
   output logic [sem_pkg::ChanBits-1:0]         rsp_out_green,
   output logic [sem_pkg::ChanBits-1:0]         rsp_out_blue,
   output logic [sem_pkg::RowOutBits-1:0]       rsp_out_row,
   output logic [sem_pkg::ColOutBits-1:0]       rsp_out_col,
   output logic                                 rsp_frame_last,
   input  logic                                 csr_write_en,
   input  logic [sem_pkg::CsrIndexBits-1:0]     csr_index,
   input  logic [sem_pkg::CsrDataBits-1:0]      csr_data
);
   localparam int WB = $clog2(MAX_WIDTH + 1);
   localparam int HB = $clog2(MAX_HEIGHT + 1);

   logic [sem_pkg::WidthRegBits-1:0]  width_ff, width_in;
   logic [sem_pkg::HeightRegBits-1:0] height_ff, height_in;
   logic [WB-1:0]      eff_w;
   logic [HB-1:0]      eff_h;
   logic               q_push, q_pop, q_full, q_valid;
   logic [1:0]         q_count;
   sem_pkg::item_type  q_in_item, q_out_item;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_en) begin
         unique case (sem_pkg::csr_index_type'(csr_index))
            sem_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_data[sem_pkg::WidthRegBits-1:0];
            sem_pkg::CSR_IMAGE_HEIGHT: height_in = csr_data[sem_pkg::HeightRegBits-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sem_pkg::WidthRegBits'(sem_pkg::WidthReset);
         height_ff <= sem_pkg::HeightRegBits'(sem_pkg::HeightReset);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // register values saturated to 1..MAX
   always_comb begin
      if (width_ff == '0) begin
         eff_w = WB'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = WB'(MAX_WIDTH);
      end else begin
         eff_w = WB'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = HB'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         eff_h = HB'(MAX_HEIGHT);
      end else begin
         eff_h = HB'(height_ff);
      end
   end

   sem_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .restart  (csr_write_en),
      .eff_w    (eff_w),
      .eff_h    (eff_h),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_flush(req_flush),
      .req_red  (req_red),
      .req_green(req_green),
      .req_blue (req_blue),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_item   (q_in_item)
   );

   sem_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_item(q_in_item),
      .pop      (q_pop),
      .head_item(q_out_item),
      .not_empty(q_valid),
      .full     (q_full),
      .count    (q_count)
   );

   sem_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .restart       (csr_write_en),
      .eff_w         (eff_w),
      .eff_h         (eff_h),
      .q_valid       (q_valid),
      .q_item        (q_out_item),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_frame_last(rsp_frame_last)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= 2'd2) else $error("queue count out of range");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full)) else $error("queue written while full");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result shown right after reset");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("queue read while empty");
endmodule
